// ===== design/lpht_pkg.sv =====
// Shared codes and controller/datapath interface types for the linear-probe hash table.
package lpht_pkg;

  // Default sizing
  localparam int MAX_SLOTS_DEF  = 1024;
  localparam int LABEL_BITS_DEF = 32;
  localparam int VALUE_BITS_DEF = 32;

  // Operation codes (input tuser)
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Result status codes (output tuser)
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_INIT_CAP = 2'd0;
  localparam logic [1:0] CFG_GROW_NUM = 2'd1;
  localparam logic [1:0] CFG_GROW_DEN = 2'd2;

  // Reset values of the configuration registers
  localparam logic [3:0] INIT_CAP_RST = 4'd3;
  localparam logic [3:0] GROW_NUM_RST = 4'd4;
  localparam logic [3:0] GROW_DEN_RST = 4'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic       accept;       // latch the input beat, clear found value
    logic       init_load;    // reload initial capacity, zero count, rewind slot pointer
    logic       s_home_op;    // slot pointer to home slot of the op label, probe count to 0
    logic       s_home_rh;    // slot pointer to home slot of the entry being rehashed
    logic       s_inc;        // next slot, wrapping at capacity
    logic       s_step_full;  // next slot over the whole memory (clearing sweep)
    logic       grow;         // double capacity, rewind slot pointer
    logic       slot_clr;     // write empty into the current slot
    logic       slot_place;   // write entry reference into the current slot
    logic       place_new;    // placed entry is the new one (else rehash index)
    logic       ent_rd_slot;  // entry read address from slot contents (else rehash index)
    logic       ent_wr;       // store op label/value as the next entry
    logic       cnt_inc;      // one more stored entry
    logic       k_clr;        // rehash index to 0
    logic       k_inc;        // next rehash index
    logic       found_ld;     // capture value of the matched entry
    logic       res_ld;       // load the result register
    logic [1:0] status;       // status code for the result register
  } lpht_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic slot_empty;   // current slot holds no entry
    logic slot_live;    // current slot refers to a stored entry
    logic lab_eq;       // read entry label equals the op label
    logic probe_last;   // lookup has probed every slot
    logic grow_ok;      // load factor reached and capacity below maximum
    logic full;         // no room for another entry
    logic s_last;       // slot pointer at last slot of current capacity
    logic s_top;        // slot pointer at last slot of the memory
    logic k_done;       // every entry rehashed
  } lpht_stat_t;

endpackage

// ===== design/linear_probe_hash_table.sv =====
// Top level of the linear-probe hash table: stream ports, config port, controller and datapath.
//
// Input stream (s_axis): one beat per operation. tuser carries the operation
// (lookup, insert, clear); tdata carries label and value. Output stream
// (m_axis): one beat per operation with status in tuser and found value,
// entry total and capacity log2 in tdata.
// Config port: cfg_wen writes cfg_data into register cfg_index (0 initial
// capacity log2, 1 growth numerator, 2 growth denominator) in the same cycle.
// One operation is in flight at a time; s_axis_tready is high only when idle.
// Each step waits on the single-port slot map and entry store reads:
//   lookup: slot read, check and entry compare for each probed slot, then the result.
//   insert: growth test, then entry store write and placement probing; with
//     growth, first clear every slot of the new capacity, then place each
//     stored entry again in insertion order, probing past occupied slots.
//   clear:  full slot map sweep.
// After reset the slot map is swept clear before the first beat is
// accepted; config writes are taken throughout.
// A finished result sits in the output register until m_axis_tready; the
// next operation is accepted meanwhile and holds only at its own completion.
module linear_probe_hash_table import lpht_pkg::*; #(
  parameter int  MAX_SLOTS  = MAX_SLOTS_DEF,
  parameter int  LABEL_BITS = LABEL_BITS_DEF,
  parameter int  VALUE_BITS = VALUE_BITS_DEF,
  localparam int SW    = $clog2(MAX_SLOTS),
  localparam int CW    = $clog2(MAX_SLOTS + 1),
  localparam int LW    = $clog2(SW + 1),
  localparam int IN_W  = ((LABEL_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((VALUE_BITS + CW + LW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [1:0]       cfg_index,
  input  logic [3:0]       cfg_data,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // label, value, zero pad
  input  logic [1:0]       s_axis_tuser,   // operation
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // found_value, entry_total, capacity_log2, zero pad
  output logic [1:0]       m_axis_tuser    // status
);

  lpht_cmd_t             cmd;
  lpht_stat_t            stat;
  logic [VALUE_BITS-1:0] res_found;
  logic [CW-1:0]         res_total;
  logic [LW-1:0]         res_cap;

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lpht_dp #(
    .MAX_SLOTS  (MAX_SLOTS),
    .LABEL_BITS (LABEL_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_label   (s_axis_tdata[LABEL_BITS-1:0]),
    .in_value   (s_axis_tdata[LABEL_BITS +: VALUE_BITS]),
    .cmd        (cmd),
    .stat       (stat),
    .res_status (m_axis_tuser),
    .res_found  (res_found),
    .res_total  (res_total),
    .res_cap    (res_cap)
  );

  // Output beat packing, lowest field first
  assign m_axis_tdata = OUT_W'({res_cap, res_total, res_found});

endmodule

// ===== design/lpht_ctrl.sv =====
// Controller state machine: sequences lookups, inserts, growth, rehash and clearing sweeps.
module lpht_ctrl import lpht_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  output logic       out_valid,
  input  logic       out_ready,
  input  lpht_stat_t stat,
  output lpht_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_LK_RD, S_LK_CHK, S_LK_CMP, S_GROW, S_GCLR,
    S_RH_NEXT, S_RH_LAB, S_PL_RD, S_PL_CHK, S_INS, S_DONE
  } state_t;

  state_t     state, state_next;
  logic [1:0] status_r, status_next;
  logic       new_ent, new_ent_next;
  logic       reply, reply_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and command decode
  always_comb begin
    state_next   = state;
    status_next  = status_r;
    new_ent_next = new_ent;
    reply_next   = reply;
    cmd          = '0;
    cmd.status   = status_r;
    cmd.place_new = new_ent;
    case (state)
      S_SWEEP: begin
        cmd.slot_clr    = 1'b1;
        cmd.s_step_full = 1'b1;
        if (stat.s_top) begin
          state_next = reply ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          case (in_op)
            OP_LOOKUP: begin
              cmd.s_home_op = 1'b1;
              state_next    = S_LK_RD;
            end
            OP_INSERT: begin
              state_next = S_GROW;
            end
            OP_CLEAR: begin
              cmd.init_load = 1'b1;
              status_next   = ST_OK;
              reply_next    = 1'b1;
              state_next    = S_SWEEP;
            end
            default: begin
              status_next = ST_OK;
              state_next  = S_DONE;
            end
          endcase
        end
      end
      // Lookup: slot read, entry read, compare
      S_LK_RD: begin
        state_next = S_LK_CHK;
      end
      S_LK_CHK: begin
        if (!stat.slot_live) begin
          status_next = ST_MISS;
          state_next  = S_DONE;
        end else begin
          cmd.ent_rd_slot = 1'b1;
          state_next      = S_LK_CMP;
        end
      end
      S_LK_CMP: begin
        if (stat.lab_eq) begin
          cmd.found_ld = 1'b1;
          status_next  = ST_OK;
          state_next   = S_DONE;
        end else if (stat.probe_last) begin
          status_next = ST_MISS;
          state_next  = S_DONE;
        end else begin
          cmd.s_inc  = 1'b1;
          state_next = S_LK_RD;
        end
      end
      // Insert: growth test
      S_GROW: begin
        new_ent_next = 1'b0;
        if (stat.grow_ok) begin
          cmd.grow   = 1'b1;
          state_next = S_GCLR;
        end else begin
          state_next = S_INS;
        end
      end
      S_GCLR: begin
        cmd.slot_clr = 1'b1;
        cmd.s_inc    = 1'b1;
        if (stat.s_last) begin
          cmd.k_clr  = 1'b1;
          state_next = S_RH_NEXT;
        end
      end
      // Rehash in insertion order
      S_RH_NEXT: begin
        state_next = stat.k_done ? S_INS : S_RH_LAB;
      end
      S_RH_LAB: begin
        cmd.s_home_rh = 1'b1;
        state_next    = S_PL_RD;
      end
      S_PL_RD: begin
        state_next = S_PL_CHK;
      end
      S_PL_CHK: begin
        if (stat.slot_empty) begin
          cmd.slot_place = 1'b1;
          if (new_ent) begin
            cmd.cnt_inc = 1'b1;
            status_next = ST_OK;
            state_next  = S_DONE;
          end else begin
            cmd.k_inc  = 1'b1;
            state_next = S_RH_NEXT;
          end
        end else begin
          cmd.s_inc  = 1'b1;
          state_next = S_PL_RD;
        end
      end
      S_INS: begin
        if (stat.full) begin
          status_next = ST_FULL;
          state_next  = S_DONE;
        end else begin
          cmd.ent_wr    = 1'b1;
          cmd.s_home_op = 1'b1;
          new_ent_next  = 1'b1;
          state_next    = S_PL_RD;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.res_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      status_r  <= ST_OK;
      new_ent   <= 1'b0;
      reply     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      status_r <= status_next;
      new_ent  <= new_ent_next;
      reply    <= reply_next;
      if (cmd.res_ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/lpht_dp.sv =====
// Datapath: slot map and entry store memories, pointers, counters and result register.
module lpht_dp import lpht_pkg::*; #(
  parameter int  MAX_SLOTS  = MAX_SLOTS_DEF,
  parameter int  LABEL_BITS = LABEL_BITS_DEF,
  parameter int  VALUE_BITS = VALUE_BITS_DEF,
  localparam int SW = $clog2(MAX_SLOTS),
  localparam int CW = $clog2(MAX_SLOTS + 1),
  localparam int LW = $clog2(SW + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [1:0]            cfg_index,
  input  logic [3:0]            cfg_data,
  input  logic [LABEL_BITS-1:0] in_label,
  input  logic [VALUE_BITS-1:0] in_value,
  input  lpht_cmd_t             cmd,
  output lpht_stat_t            stat,
  output logic [1:0]            res_status,
  output logic [VALUE_BITS-1:0] res_found,
  output logic [CW-1:0]         res_total,
  output logic [LW-1:0]         res_cap
);

  localparam int GW = CW + 4;

  // Clamp the initial capacity into 1..log2(MAX_SLOTS)
  function automatic logic [LW-1:0] clamp_cap(input logic [3:0] c);
    logic [LW-1:0] r;
    if (c == 4'd0) begin
      r = LW'(1);
    end else if (int'(c) > SW) begin
      r = LW'(SW);
    end else begin
      r = LW'(c);
    end
    return r;
  endfunction

  logic [3:0]            init_cap, grow_num, grow_den;
  logic [LABEL_BITS-1:0] op_label;
  logic [VALUE_BITS-1:0] op_value, found;
  logic [LW-1:0]         cap_log2;
  logic [CW-1:0]         count, k;
  logic [SW-1:0]         s, n;
  logic [CW-1:0]         cap_val;
  logic [SW-1:0]         mask, ent_addr;
  logic [GW-1:0]         load_lhs, load_rhs;

  logic [CW-1:0]         slot_mem [MAX_SLOTS];
  logic [LABEL_BITS-1:0] lab_mem  [MAX_SLOTS];
  logic [VALUE_BITS-1:0] val_mem  [MAX_SLOTS];
  logic [CW-1:0]         slot_q;
  logic [LABEL_BITS-1:0] lab_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [CW-1:0]         place_ref;

  assign cap_val  = CW'(1) << cap_log2;
  assign mask     = SW'(cap_val - CW'(1));
  assign load_lhs = GW'(count) * GW'(grow_num);
  assign load_rhs = GW'(cap_val) * GW'(grow_den);
  assign ent_addr = cmd.ent_rd_slot ? SW'(slot_q - CW'(1)) : k[SW-1:0];
  assign place_ref = (cmd.place_new ? count : k) + CW'(1);

  // Status back to the controller
  always_comb begin
    stat.slot_empty = (slot_q == '0);
    stat.slot_live  = (slot_q != '0) && (slot_q <= count);
    stat.lab_eq     = (lab_q == op_label);
    stat.probe_last = (n == mask);
    stat.grow_ok    = (load_lhs >= load_rhs) && (cap_log2 < LW'(SW));
    stat.full       = (count >= cap_val) || (count >= CW'(MAX_SLOTS));
    stat.s_last     = (s == mask);
    stat.s_top      = (s == '1);
    stat.k_done     = (k == count);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      init_cap <= INIT_CAP_RST;
      grow_num <= GROW_NUM_RST;
      grow_den <= GROW_DEN_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_INIT_CAP: init_cap <= cfg_data;
        CFG_GROW_NUM: grow_num <= cfg_data;
        CFG_GROW_DEN: grow_den <= cfg_data;
        default: ;
      endcase
    end
  end

  // Table state: capacity, entry count, pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_log2 <= clamp_cap(INIT_CAP_RST);
      count    <= '0;
      s        <= '0;
      n        <= '0;
      k        <= '0;
    end else begin
      if (cmd.init_load) begin
        cap_log2 <= clamp_cap(init_cap);
        count    <= '0;
        s        <= '0;
      end
      if (cmd.grow) begin
        cap_log2 <= cap_log2 + LW'(1);
        s        <= '0;
      end
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end
      // Home slot comes from the incoming beat while it is being accepted
      if (cmd.s_home_op) begin
        s <= SW'(cmd.accept ? in_label : op_label) & mask;
        n <= '0;
      end
      if (cmd.s_home_rh) begin
        s <= SW'(lab_q) & mask;
      end
      if (cmd.s_inc) begin
        s <= (s + SW'(1)) & mask;
        n <= n + SW'(1);
      end
      if (cmd.s_step_full) begin
        s <= s + SW'(1);
      end
      if (cmd.k_clr) begin
        k <= '0;
      end
      if (cmd.k_inc) begin
        k <= k + CW'(1);
      end
    end
  end

  // Operand and found-value registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_label <= in_label;
      op_value <= in_value;
      found    <= '0;
    end else if (cmd.found_ld) begin
      found <= val_q;
    end
  end

  // Slot map memory
  always_ff @(posedge clk) begin
    if (cmd.slot_clr) begin
      slot_mem[s] <= '0;
    end else if (cmd.slot_place) begin
      slot_mem[s] <= place_ref;
    end
    slot_q <= slot_mem[s];
  end

  // Entry store memories
  always_ff @(posedge clk) begin
    if (cmd.ent_wr) begin
      lab_mem[count[SW-1:0]] <= op_label;
      val_mem[count[SW-1:0]] <= op_value;
    end
    lab_q <= lab_mem[ent_addr];
    val_q <= val_mem[ent_addr];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      res_status <= cmd.status;
      res_found  <= found;
      res_total  <= count;
      res_cap    <= cap_log2;
    end
  end

endmodule
